// ===== src/gradient_bar_test_pattern_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the gradient bar test pattern
// Both macros sample on clock and are disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef GRADIENT_BAR_TEST_PATTERN_ASSERT_SVH
`define GRADIENT_BAR_TEST_PATTERN_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define GBTP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the cycle after the trigger
`define GBTP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/gbtp_pkg.sv =====
// ---------------------------------------------------------------------------
// gbtp_pkg: shared types and constants
// Widths, register indexes, beat payloads and pipeline link types.
// ---------------------------------------------------------------------------
package gbtp_pkg;

   // basic widths
   localparam int COORD_BITS = 12;
   localparam int LEVEL_BITS = 16;
   localparam int STEP_BITS  = 5;
   localparam int TIME_BITS  = 16;
   localparam int DIM_BITS   = COORD_BITS + 1;
   localparam int POS_BITS   = COORD_BITS + STEP_BITS;
   localparam int BW_BITS    = DIM_BITS - 4;
   localparam int SPAN_BITS  = DIM_BITS - 3;
   localparam int PROD_BITS  = TIME_BITS + SPAN_BITS;

   // divider geometry: bar quotient stays below 2^TIME_BITS / 8
   localparam int DIV_BITS   = DIM_BITS + 1;
   localparam int BAR_Q_BITS = TIME_BITS - 3;
   localparam int DIV_STEPS  = (LEVEL_BITS > BAR_Q_BITS) ? LEVEL_BITS : BAR_Q_BITS;
   localparam int DVD_BITS   = DIV_STEPS + DIV_BITS;

   localparam int BAR_MIN = 2;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;

   // configuration port
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = (TIME_BITS > DIM_BITS) ? TIME_BITS : DIM_BITS;

   localparam logic [CSR_IDX_BITS-1:0] CSR_FULL_WIDTH  = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_FULL_HEIGHT = CSR_IDX_BITS'(1);
   localparam logic [CSR_IDX_BITS-1:0] CSR_REGION_LEFT = CSR_IDX_BITS'(2);
   localparam logic [CSR_IDX_BITS-1:0] CSR_REGION_TOP  = CSR_IDX_BITS'(3);
   localparam logic [CSR_IDX_BITS-1:0] CSR_SAMPLE_STEP = CSR_IDX_BITS'(4);
   localparam logic [CSR_IDX_BITS-1:0] CSR_TIME_STEP   = CSR_IDX_BITS'(5);

   // divider lanes
   localparam int NUM_LANES = 3;
   localparam int LANE_RED  = 0;
   localparam int LANE_GRN  = 1;
   localparam int LANE_BAR  = 2;

   typedef struct packed {
      logic [DIM_BITS-1:0]   full_width;
      logic [DIM_BITS-1:0]   full_height;
      logic [COORD_BITS-1:0] region_left;
      logic [COORD_BITS-1:0] region_top;
      logic [STEP_BITS-1:0]  sample_step;
      logic [TIME_BITS-1:0]  time_step;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      full_width:  DIM_BITS'(1920),
      full_height: DIM_BITS'(1080),
      region_left: '0,
      region_top:  '0,
      sample_step: STEP_BITS'(1),
      time_step:   '0
   };

   typedef struct packed {
      logic [COORD_BITS-1:0] pix_col;
      logic [COORD_BITS-1:0] pix_row;
   } req_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] red_level;
      logic [LEVEL_BITS-1:0] green_level;
      logic                  blue_on;
      logic                  alpha_on;
   } rsp_type;

   // one divider lane: partial remainder, dividend bits / quotient bits, divisor
   typedef struct packed {
      logic [DIV_BITS-1:0]  rem;
      logic [DIV_STEPS-1:0] lq;
      logic [DIV_BITS-1:0]  dsr;
   } lane_type;

   typedef lane_type [NUM_LANES-1:0] lane_vec_type;

   // per-pixel data that rides alongside the dividers
   typedef struct packed {
      logic [POS_BITS-1:0] xpos;
      logic                red_zero;
      logic                red_sat;
      logic                grn_zero;
      logic                grn_sat;
   } side_type;

   typedef struct packed {
      logic         valid;
      side_type     side;
      lane_vec_type lanes;
   } link_type;

   // bar width: a sixteenth of the image, at least two pixels
   function automatic logic [BW_BITS-1:0] bar_width(input logic [DIM_BITS-1:0] width);
      logic [BW_BITS-1:0] sixteenth;
      sixteenth = width[DIM_BITS-1:4];
      return (sixteenth < BW_BITS'(BAR_MIN)) ? BW_BITS'(BAR_MIN) : sixteenth;
   endfunction

endpackage

// ===== src/gbtp_div_pipe.sv =====
// ---------------------------------------------------------------------------
// gbtp_div_pipe: pipelined restoring divider, three lanes
// One quotient bit per stage for red, green and the bar position modulo.
// ---------------------------------------------------------------------------
module gbtp_div_pipe (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  gbtp_pkg::link_type stage_in,
   output gbtp_pkg::link_type stage_out
);

   localparam int Steps   = gbtp_pkg::DIV_STEPS;
   localparam int DivBits = gbtp_pkg::DIV_BITS;

   logic [Steps-1:0]       valid_ff;
   logic [Steps-1:0]       valid_in;
   gbtp_pkg::side_type     side_ff  [Steps];
   gbtp_pkg::side_type     side_in  [Steps];
   gbtp_pkg::lane_vec_type lanes_ff [Steps];
   gbtp_pkg::lane_vec_type lanes_in [Steps];

   // one compare-subtract step; next dividend bit enters from the top of lq
   function automatic gbtp_pkg::lane_type div_step(input gbtp_pkg::lane_type cur);
      logic [DivBits:0]   trial;
      gbtp_pkg::lane_type nxt;
      trial = {cur.rem, cur.lq[Steps-1]};
      nxt   = cur;
      if (trial >= {1'b0, cur.dsr}) begin
         nxt.rem = DivBits'(trial - {1'b0, cur.dsr});
         nxt.lq  = {cur.lq[Steps-2:0], 1'b1};
      end else begin
         nxt.rem = trial[DivBits-1:0];
         nxt.lq  = {cur.lq[Steps-2:0], 1'b0};
      end
      return nxt;
   endfunction

   // next values for every stage
   always_comb begin
      valid_in   = {valid_ff[Steps-2:0], stage_in.valid};
      side_in[0] = stage_in.side;
      for (int l = 0; l < gbtp_pkg::NUM_LANES; l++) begin
         lanes_in[0][l] = div_step(stage_in.lanes[l]);
      end
      for (int s = 1; s < Steps; s++) begin
         side_in[s] = side_ff[s-1];
         for (int l = 0; l < gbtp_pkg::NUM_LANES; l++) begin
            lanes_in[s][l] = div_step(lanes_ff[s-1][l]);
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < Steps; s++) begin
            side_ff[s]  <= side_in[s];
            lanes_ff[s] <= lanes_in[s];
         end
      end
   end

   always_comb begin
      stage_out.valid = valid_ff[Steps-1];
      stage_out.side  = side_ff[Steps-1];
      stage_out.lanes = lanes_ff[Steps-1];
   end

endmodule

// ===== src/gbtp_front.sv =====
// ---------------------------------------------------------------------------
// gbtp_front: coordinate mapping and divider setup
// Stage A maps the pixel to full-resolution space; stage B forms the
// dividends, divisors and edge flags for the divider lanes.
// ---------------------------------------------------------------------------
module gbtp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  gbtp_pkg::cfg_type  cfg,
   input  logic               req_valid,
   input  gbtp_pkg::req_type  req_data,
   output gbtp_pkg::link_type stage_out
);

   localparam int PosBits  = gbtp_pkg::POS_BITS;
   localparam int DimBits  = gbtp_pkg::DIM_BITS;
   localparam int DvdBits  = gbtp_pkg::DVD_BITS;
   localparam int DivBits  = gbtp_pkg::DIV_BITS;
   localparam int Steps    = gbtp_pkg::DIV_STEPS;
   localparam int ProdBits = gbtp_pkg::PROD_BITS;

   // stage A
   logic               map_valid_ff;
   logic [PosBits-1:0] xpos_ff, xpos_in;
   logic [PosBits-1:0] ypos_ff, ypos_in;

   // stage B
   logic                   setup_valid_ff;
   gbtp_pkg::side_type     side_ff, side_in;
   gbtp_pkg::lane_vec_type lanes_ff, lanes_in;

   logic [DimBits-1:0]         wden, hden;
   logic [ProdBits-1:0]        bar_prod;
   logic [DivBits-1:0]         bar_mod;
   logic [gbtp_pkg::SPAN_BITS-1:0] bar_span;

   // gradient lane: (2*pos*LMAX + den) / (2*den), pos below den
   function automatic gbtp_pkg::lane_type grad_lane(input logic [PosBits-1:0] pos,
                                                    input logic [DimBits-1:0] dim);
      logic [DimBits-1:0] den;
      logic [DvdBits-1:0] pos_w;
      logic [DvdBits-1:0] num;
      gbtp_pkg::lane_type lane;
      den   = dim - DimBits'(1);
      pos_w = DvdBits'(pos[DimBits-1:0]);
      num   = (pos_w << (gbtp_pkg::LEVEL_BITS + 1)) - (pos_w << 1) + DvdBits'(den);
      lane.rem = num[DvdBits-1:Steps];
      lane.lq  = num[Steps-1:0];
      lane.dsr = {den, 1'b0};
      return lane;
   endfunction

   // stage A: X = left + col * step, Y = top + row * step
   always_comb begin
      xpos_in = PosBits'(cfg.region_left)
              + PosBits'(req_data.pix_col) * PosBits'(cfg.sample_step);
      ypos_in = PosBits'(cfg.region_top)
              + PosBits'(req_data.pix_row) * PosBits'(cfg.sample_step);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff <= 1'b0;
      end else if (advance) begin
         map_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         xpos_ff <= xpos_in;
         ypos_ff <= ypos_in;
      end
   end

   // stage B: edge flags and divider operands
   always_comb begin
      wden     = cfg.full_width - DimBits'(1);
      hden     = cfg.full_height - DimBits'(1);
      bar_span = cfg.full_width[DimBits-1:3];
      bar_prod = ProdBits'(cfg.time_step) * ProdBits'(bar_span);
      bar_mod  = DivBits'(cfg.full_width) + DivBits'(gbtp_pkg::bar_width(cfg.full_width));

      side_in.xpos     = xpos_ff;
      side_in.red_zero = cfg.full_width <= DimBits'(1);
      side_in.red_sat  = xpos_ff >= PosBits'(wden);
      side_in.grn_zero = cfg.full_height <= DimBits'(1);
      side_in.grn_sat  = ypos_ff >= PosBits'(hden);

      lanes_in[gbtp_pkg::LANE_RED] = grad_lane(xpos_ff, cfg.full_width);
      lanes_in[gbtp_pkg::LANE_GRN] = grad_lane(ypos_ff, cfg.full_height);

      // bar start = (time * W/8) mod (W + bar width)
      lanes_in[gbtp_pkg::LANE_BAR].rem = DivBits'(bar_prod[ProdBits-1:Steps]);
      lanes_in[gbtp_pkg::LANE_BAR].lq  = bar_prod[Steps-1:0];
      lanes_in[gbtp_pkg::LANE_BAR].dsr = bar_mod;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_valid_ff <= 1'b0;
      end else if (advance) begin
         setup_valid_ff <= map_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff  <= side_in;
         lanes_ff <= lanes_in;
      end
   end

   always_comb begin
      stage_out.valid = setup_valid_ff;
      stage_out.side  = side_ff;
      stage_out.lanes = lanes_ff;
   end

endmodule

// ===== src/gbtp_out.sv =====
// ---------------------------------------------------------------------------
// gbtp_out: color assembly, output register and skid stage
// Picks levels from quotients or edge flags, tests the bar, and holds
// results in an output register backed by a one-beat skid.
// ---------------------------------------------------------------------------
`include "gradient_bar_test_pattern_assert.svh"

module gbtp_out (
   input  logic               clock,
   input  logic               reset,
   input  gbtp_pkg::cfg_type  cfg,
   input  gbtp_pkg::link_type stage_in,
   output logic               advance,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output gbtp_pkg::rsp_type  rsp_data
);

   localparam int DivBits = gbtp_pkg::DIV_BITS;
   localparam int CmpBits = gbtp_pkg::POS_BITS + DivBits + 1;

   logic              out_valid_ff, out_valid_in;
   gbtp_pkg::rsp_type out_data_ff, out_data_in;
   logic              skid_valid_ff, skid_valid_in;
   gbtp_pkg::rsp_type skid_data_ff, skid_data_in;

   gbtp_pkg::rsp_type  result;
   logic [DivBits-1:0] bar_start;
   logic [DivBits:0]   bar_stop;
   logic               arrive;
   logic               out_free;

   // color of the pixel leaving the divider
   always_comb begin
      bar_start = stage_in.lanes[gbtp_pkg::LANE_BAR].rem;
      bar_stop  = {1'b0, bar_start} + (DivBits + 1)'(gbtp_pkg::bar_width(cfg.full_width));

      if (stage_in.side.red_zero) begin
         result.red_level = '0;
      end else if (stage_in.side.red_sat) begin
         result.red_level = gbtp_pkg::LEVEL_MAX;
      end else begin
         result.red_level = stage_in.lanes[gbtp_pkg::LANE_RED].lq[gbtp_pkg::LEVEL_BITS-1:0];
      end

      if (stage_in.side.grn_zero) begin
         result.green_level = '0;
      end else if (stage_in.side.grn_sat) begin
         result.green_level = gbtp_pkg::LEVEL_MAX;
      end else begin
         result.green_level = stage_in.lanes[gbtp_pkg::LANE_GRN].lq[gbtp_pkg::LEVEL_BITS-1:0];
      end

      result.blue_on  = (CmpBits'(stage_in.side.xpos) >= CmpBits'(bar_start))
                     && (CmpBits'(stage_in.side.xpos) <  CmpBits'(bar_stop));
      result.alpha_on = 1'b1;
   end

   // pipeline moves whenever the skid is empty
   assign advance  = !skid_valid_ff;
   assign arrive   = advance && stage_in.valid;
   assign out_free = !out_valid_ff || !rsp_stall;

   // output register and skid control
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = arrive;
            out_data_in  = result;
         end
      end else if (arrive) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // checks
   `GBTP_ASSERT_NOW(a_skid_behind_out, skid_valid_ff, out_valid_ff, "skid holds a beat while output register is empty")
   `GBTP_ASSERT_NOW(a_skid_fill_stalled, $rose(skid_valid_ff), $past(out_valid_ff && rsp_stall), "skid filled without a stalled output")
   `GBTP_ASSERT_NEXT(a_skid_drains, skid_valid_ff && !rsp_stall, !skid_valid_ff, "skid did not drain once the stall dropped")

endmodule

// ===== src/gradient_bar_test_pattern.sv =====
// ---------------------------------------------------------------------------
// gradient_bar_test_pattern: gradient and moving-bar video test pattern
// Channels: req_ takes one output pixel coordinate per beat, rsp_ returns
// its color (red/green gradients in 0.16, blue bar flag, alpha always on).
// Registers are written through csr_ by index; write them only while idle.
// Path: the mapping stage takes a beat at the accept edge, then the
// setup stage, one divider stage per quotient bit and the output
// register pass it on to rsp_.
// Throughput: one pixel per clock while req_stall is low, set by the pipe.
// Reset: registers return to 1920x1080, origin 0, step 1, time 0; all
// pipeline valid bits clear and rsp_valid drops.
// Stall: the output register holds its beat; one more beat lands in a skid,
// after which req_stall rises (registered) until the skid drains.
// ---------------------------------------------------------------------------
module gradient_bar_test_pattern (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  gbtp_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output gbtp_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_write,
   input  logic [gbtp_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [gbtp_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   gbtp_pkg::cfg_type  cfg_ff, cfg_in;
   gbtp_pkg::link_type front_link;
   gbtp_pkg::link_type div_link;
   logic               advance;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            gbtp_pkg::CSR_FULL_WIDTH:  cfg_in.full_width  = csr_wdata[gbtp_pkg::DIM_BITS-1:0];
            gbtp_pkg::CSR_FULL_HEIGHT: cfg_in.full_height = csr_wdata[gbtp_pkg::DIM_BITS-1:0];
            gbtp_pkg::CSR_REGION_LEFT: cfg_in.region_left = csr_wdata[gbtp_pkg::COORD_BITS-1:0];
            gbtp_pkg::CSR_REGION_TOP:  cfg_in.region_top  = csr_wdata[gbtp_pkg::COORD_BITS-1:0];
            gbtp_pkg::CSR_SAMPLE_STEP: cfg_in.sample_step = csr_wdata[gbtp_pkg::STEP_BITS-1:0];
            gbtp_pkg::CSR_TIME_STEP:   cfg_in.time_step   = csr_wdata[gbtp_pkg::TIME_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= gbtp_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = !advance;

   gbtp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_data  (req_data),
      .stage_out (front_link)
   );

   gbtp_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .stage_in  (front_link),
      .stage_out (div_link)
   );

   gbtp_out u_out (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .stage_in  (div_link),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
